// ----- rtl/seven_segment_scan_shift_driver_assert.svh -----
// assertion macros shared by the display driver rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef SEVEN_SEGMENT_SCAN_SHIFT_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_SHIFT_DRIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define SSSD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("sssd assertion failed");

// checked on every edge, reset included
`define SSSD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sssd assertion failed");

`else

`define SSSD_ASSERT(label, clk, rstn, prop)
`define SSSD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/sssd_pkg.sv -----
// shared types, constants and the segment decoder of the display driver
// no dependencies
package sssd_pkg;

    localparam int DIGITS_DEF = 8;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = 8;
    localparam int SEG_W      = 8;
    localparam int WORD_W     = 2 * SEG_W;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_W - 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [VAL_W-1:0] BLANK_VALUE = 8'd128;
    localparam logic [SEG_W-1:0] POINT_MASK  = 8'b1000_0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // segment pattern for one digit, bit 7 is the decimal point
    function automatic logic [SEG_W-1:0] seg_decode(input logic [VAL_W-1:0] value,
                                                     input logic point);
        logic [SEG_W-1:0] seg;
        unique case (value)
            8'd0:    seg = 8'b0011_1111;
            8'd1:    seg = 8'b0000_0110;
            8'd2:    seg = 8'b0101_1011;
            8'd3:    seg = 8'b0100_1111;
            8'd4:    seg = 8'b0110_0110;
            8'd5:    seg = 8'b0110_1101;
            8'd6:    seg = 8'b0111_1101;
            8'd7:    seg = 8'b0000_0111;
            8'd8:    seg = 8'b0111_1111;
            8'd9:    seg = 8'b0110_1111;
            default: seg = '0;
        endcase
        if (point) begin
            seg = seg | POINT_MASK;
        end
        return seg;
    endfunction

endpackage

// ----- rtl/sssd_front.sv -----
// front end: takes requests, keeps the digit store and scan pointer,
// and turns each scan tick into a 16-bit frame for the queue; uses sssd_pkg
module sssd_front #(
    parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [sssd_pkg::IDX_W-1:0]    s_digit_index,
    input  logic [sssd_pkg::VAL_W-1:0]    s_digit_value,
    input  logic                          s_point_on,
    input  sssd_pkg::q_stat_t             q_stat,
    output logic                          push,
    output logic [sssd_pkg::WORD_W-1:0]   push_word
);
    import sssd_pkg::*;

    localparam int PTR_W = $clog2(DIGITS);
    localparam logic [IDX_W:0]   DIGITS_L = (IDX_W + 1)'(DIGITS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DIGITS - 1);

    logic [VAL_W-1:0] val_reg [DIGITS];
    logic [DIGITS-1:0] pt_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    logic             accept;
    logic             wr_en;
    logic [PTR_W-1:0] wr_idx;
    logic [SEG_W-1:0] seg;
    logic [SEG_W-1:0] sel;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    // writes past the digit count are dropped
    assign wr_en   = accept && (s_operation == OP_WRITE) && ({1'b0, s_digit_index} < DIGITS_L);
    assign wr_idx  = s_digit_index[PTR_W-1:0];
    assign push    = accept && (s_operation == OP_SCAN);

    assign seg       = seg_decode(val_reg[ptr_reg], pt_reg[ptr_reg]);
    assign sel       = SEG_W'(1) << ptr_reg;
    assign push_word = {sel, ~seg};

    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGITS; i++) begin
                val_reg[i] <= BLANK_VALUE;
            end
            pt_reg  <= '0;
            ptr_reg <= '0;
        end else begin
            if (wr_en) begin
                val_reg[wr_idx] <= s_digit_value;
                pt_reg[wr_idx]  <= s_point_on;
            end
            if (push) begin
                ptr_reg <= ptr_next;
            end
        end
    end

endmodule

// ----- rtl/sssd_fifo.sv -----
// short frame queue between the front end and the shifter
// uses sssd_pkg for widths and depth
module sssd_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [sssd_pkg::WORD_W-1:0] push_word,
    input  logic                        pop,
    output logic [sssd_pkg::WORD_W-1:0] pop_word,
    output sssd_pkg::q_stat_t           q_stat
);
    import sssd_pkg::*;

    logic [WORD_W-1:0]  mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_word     = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (FIFO_AW + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/sssd_shifter.sv -----
// back end: shifts each queued frame out msb first, one bit per request
// uses sssd_pkg
module sssd_shifter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sssd_pkg::q_stat_t           q_stat,
    input  logic [sssd_pkg::WORD_W-1:0] pop_word,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_serial_bit,
    output logic                        m_latch_now
);
    import sssd_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              take;
    logic              last_take;

    assign m_valid      = busy_reg;
    assign m_serial_bit = word_reg[WORD_W-1];
    assign m_latch_now  = (cnt_reg == LAST_BIT);

    assign take      = busy_reg && m_ready;
    assign last_take = take && (cnt_reg == LAST_BIT);
    // load the next frame when idle or as the latch bit leaves
    assign pop       = !q_stat.empty && (!busy_reg || last_take);

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg <= pop_word;
        end else if (take) begin
            word_reg <= {word_reg[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (last_take) begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end else if (take) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/seven_segment_scan_shift_driver.sv -----
// Eight-digit multiplexed seven-segment driver for a chain of serial shift registers.
// A write request (operation 0) sets the value and decimal point of one digit and
// produces nothing; writes to a position at or past DIGITS are dropped. A scan tick
// (operation 1) takes the digit under the scan pointer, decodes 0 to 9 to segments
// (anything else is blank, the point still lights), and emits 16 serial bits msb
// first: the one-hot digit select byte, then the inverted segment byte, with
// latch_now high on the last bit. The pointer then advances and wraps after the
// last digit. The shifter sends one bit per cycle while m_ready is high; a two-frame
// queue lets the front end take further requests while a frame is still shifting,
// and writes are absorbed while the queue has room.
// Depends on sssd_pkg, sssd_front, sssd_fifo, sssd_shifter and the assertion header.
`include "seven_segment_scan_shift_driver_assert.svh"

module seven_segment_scan_shift_driver #(
    parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [sssd_pkg::IDX_W-1:0] s_digit_index,
    input  logic [sssd_pkg::VAL_W-1:0] s_digit_value,
    input  logic                       s_point_on,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_serial_bit,
    output logic                       m_latch_now
);
    import sssd_pkg::*;

    q_stat_t           q_stat;
    logic              push;
    logic              pop;
    logic [WORD_W-1:0] push_word;
    logic [WORD_W-1:0] pop_word;

    sssd_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_digit_index (s_digit_index),
        .s_digit_value (s_digit_value),
        .s_point_on    (s_point_on),
        .q_stat        (q_stat),
        .push          (push),
        .push_word     (push_word)
    );

    sssd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .q_stat    (q_stat)
    );

    sssd_shifter u_shifter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .pop_word     (pop_word),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_serial_bit (m_serial_bit),
        .m_latch_now  (m_latch_now)
    );

    // queue never written while full, never read while empty
    `SSSD_ASSERT(a_no_overflow, aclk, aresetn, !(push && q_stat.full))
    `SSSD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && q_stat.empty))
    // output goes quiet after the latch bit when nothing is queued
    `SSSD_ASSERT(a_idle_after_latch, aclk, aresetn,
                 (m_valid && m_ready && m_latch_now && q_stat.empty) |=> !m_valid)
    `SSSD_ASSERT_ALWAYS(a_quiet_out_of_reset, aclk, !aresetn |=> !m_valid)

endmodule

// ----- test/seven_segment_scan_shift_driver_tb.sv -----
// testbench for seven_segment_scan_shift_driver: digit writes and scan ticks go in,
// every serial bit that comes out is checked against a local model of the display
// depends on sssd_pkg and the driver rtl
module seven_segment_scan_shift_driver_tb;

    localparam int DIGIT_COUNT  = sssd_pkg::DIGITS_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        op;
        logic [2:0]  idx;
        logic [7:0]  val;
        logic        pt;
        logic        typed;
        logic [15:0] frame;
    } row_t;

    typedef struct packed {
        logic serial_bit;
        logic latch_now;
    } shift_bit_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} stall_mode_t;

    // frames typed in are the ones readable at a glance: select byte, then ~segments
    localparam row_t DIRECTED_ROWS [0:19] = '{
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h01FF},
        '{sssd_pkg::OP_WRITE, 3'd1, 8'd8,   1'b1, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h0200},
        '{sssd_pkg::OP_WRITE, 3'd2, 8'd0,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_WRITE, 3'd3, 8'd9,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_WRITE, 3'd4, 8'd10,  1'b1, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h107F},
        '{sssd_pkg::OP_WRITE, 3'd5, 8'd255, 1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h20FF},
        '{sssd_pkg::OP_WRITE, 3'd6, 8'd1,   1'b1, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_WRITE, 3'd7, 8'd7,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h01FF},
        '{sssd_pkg::OP_WRITE, 3'd0, 8'd5,   1'b1, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd7, 8'd255, 1'b1, 1'b1, 16'h0200},
        '{sssd_pkg::OP_WRITE, 3'd2, 8'd128, 1'b1, 1'b0, 16'h0000},
        '{sssd_pkg::OP_SCAN,  3'd0, 8'd0,   1'b0, 1'b1, 16'h047F}
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_operation;
    logic [2:0] s_digit_index;
    logic [7:0] s_digit_value;
    logic       s_point_on;
    logic       m_valid;
    logic       m_ready;
    logic       m_serial_bit;
    logic       m_latch_now;

    logic [7:0]  shown_value [DIGIT_COUNT];
    logic        shown_point [DIGIT_COUNT];
    int unsigned scan_digit;
    shift_bit_t  pending_bits [$];
    int          error_count = 0;
    int unsigned bits_checked = 0;
    int          idle_cycles = 0;
    bit          hold_request = 1'b0;

    seven_segment_scan_shift_driver #(.DIGITS(DIGIT_COUNT)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_digit_index (s_digit_index),
        .s_digit_value (s_digit_value),
        .s_point_on    (s_point_on),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_serial_bit  (m_serial_bit),
        .m_latch_now   (m_latch_now)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] numeral_segments(input logic [7:0] value);
        case (value)
            8'd0:    return 8'h3F;
            8'd1:    return 8'h06;
            8'd2:    return 8'h5B;
            8'd3:    return 8'h4F;
            8'd4:    return 8'h66;
            8'd5:    return 8'h6D;
            8'd6:    return 8'h7D;
            8'd7:    return 8'h07;
            8'd8:    return 8'h7F;
            8'd9:    return 8'h6F;
            default: return 8'h00;
        endcase
    endfunction

    // updates the display model; a scan tick yields the 16-bit frame it shifts out
    task automatic apply_request(input logic op, input logic [2:0] idx,
                                 input logic [7:0] val, input logic pt,
                                 output logic made_frame, output logic [15:0] frame);
        logic [7:0] seg;
        made_frame = 1'b0;
        frame = '0;
        if (op == sssd_pkg::OP_WRITE) begin
            if (idx < DIGIT_COUNT) begin
                shown_value[idx] = val;
                shown_point[idx] = pt;
            end
        end else begin
            seg = numeral_segments(shown_value[scan_digit]);
            if (shown_point[scan_digit]) begin
                seg = seg | sssd_pkg::POINT_MASK;
            end
            frame = {8'(1 << scan_digit), ~seg};
            made_frame = 1'b1;
            scan_digit = (scan_digit == DIGIT_COUNT - 1) ? 0 : scan_digit + 1;
        end
    endtask

    task automatic send_request(input row_t r);
        logic        made;
        logic [15:0] frame;
        s_valid       <= 1'b1;
        s_operation   <= r.op;
        s_digit_index <= r.idx;
        s_digit_value <= r.val;
        s_point_on    <= r.pt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(r.op, r.idx, r.val, r.pt, made, frame);
        if (r.typed) begin
            frame = r.frame;
        end
        if (made) begin
            // msb first, latch marks the last bit
            for (int k = 15; k >= 0; k--) begin
                pending_bits.push_back('{serial_bit: frame[k], latch_now: (k == 0)});
            end
        end
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid       <= 1'b0;
        s_operation   <= 1'($urandom);
        s_digit_index <= 3'($urandom);
        s_digit_value <= 8'($urandom);
        s_point_on    <= 1'($urandom);
        repeat (cycles) @(negedge aclk);
    endtask

    function automatic row_t random_row();
        row_t r;
        r.op  = ($urandom_range(0, 99) < 45) ? sssd_pkg::OP_SCAN : sssd_pkg::OP_WRITE;
        r.idx = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            7:       r.val = 8'($urandom_range(10, 127));
            8:       r.val = 8'($urandom_range(128, 255));
            9:       r.val = 8'($urandom);
            default: r.val = 8'($urandom_range(0, 9));
        endcase
        r.pt    = 1'($urandom);
        r.typed = 1'b0;
        r.frame = '0;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic want,
                                          input logic got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("mismatch on %s at output bit %0d: expected %0b, got %0b",
                     what, bits_checked, want, got);
        end
    endfunction

    initial begin : stimulus
        int d;
        int n;
        int burst_left;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= sssd_pkg::OP_WRITE;
        s_digit_index <= '0;
        s_digit_value <= '0;
        s_point_on    <= 1'b0;
        scan_digit = 0;
        for (d = 0; d < DIGIT_COUNT; d++) begin
            shown_value[d] = sssd_pkg::BLANK_VALUE;
            shown_point[d] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (n = 0; n < $size(DIRECTED_ROWS); n++) begin
            send_request(DIRECTED_ROWS[n]);
            if ($urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 4));
            end
        end

        // the receiver takes its long hold-off early in the random part
        hold_request = 1'b1;
        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 2) != 0) begin
                    idle_sender($urandom_range(1, 8));
                end
            end
            send_request(random_row());
            burst_left--;
        end

        s_valid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_bits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : receiver
        int          span;
        stall_mode_t mode;
        bit          held;
        held = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            span = $urandom_range(8, 64);
            mode = stall_mode_t'($urandom_range(0, 2));
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_COIN:   m_ready <= 1'($urandom);
                    default:      m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : bit_checker
        shift_bit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bits.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("output bit %0d with nothing expected: serial %0b latch %0b",
                             bits_checked, m_serial_bit, m_latch_now);
                end
            end else begin
                want = pending_bits.pop_front();
                if (m_serial_bit !== want.serial_bit) begin
                    note_mismatch("serial_bit", want.serial_bit, m_serial_bit);
                end
                if (m_latch_now !== want.latch_now) begin
                    note_mismatch("latch_now", want.latch_now, m_latch_now);
                end
            end
            bits_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout: no request or output bit moved for %0d cycles",
                         IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

// ----- seven_segment_scan_shift_driver.f -----
+incdir+rtl
rtl/sssd_pkg.sv
rtl/sssd_front.sv
rtl/sssd_fifo.sv
rtl/sssd_shifter.sv
rtl/seven_segment_scan_shift_driver.sv
test/seven_segment_scan_shift_driver_tb.sv
